// ===== src/tlla_pkg.sv =====
// ----------------------------------------------------------------------------
// tlla_pkg: shared types and constants
// Board geometry, cell and command codes, and the rule bundle that is
// handed to the cell chain.
// ----------------------------------------------------------------------------
package tlla_pkg;

	localparam int MAX_COLS   = 64;
	localparam int MAX_ROWS   = 64;
	localparam int COL_W      = $clog2(MAX_COLS);
	localparam int ROW_W      = $clog2(MAX_ROWS);
	localparam int SIZE_W     = 7;
	localparam int CELL_W     = 2;
	localparam int ROW_BITS   = MAX_COLS * CELL_W;
	localparam int CNT_W      = 4;
	localparam int MASK_W     = 9;
	localparam int GEN_W      = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 9;

	localparam logic [CELL_W-1:0] CELL_DEAD  = 2'd0;
	localparam logic [CELL_W-1:0] CELL_LIVE  = 2'd1;
	localparam logic [CELL_W-1:0] CELL_DYING = 2'd2;
	localparam logic [CELL_W-1:0] CELL_BAD   = 2'd3;

	localparam logic [1:0] MODE_WRITE   = 2'd0;
	localparam logic [1:0] MODE_READ    = 2'd1;
	localparam logic [1:0] MODE_ADVANCE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_BIRTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SURVIVE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THREE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COLS    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 3'd4;

	localparam logic [SIZE_W-1:0] MIN_SIZE  = 7'd3;
	localparam logic [SIZE_W-1:0] COLS_MAX  = SIZE_W'(MAX_COLS);
	localparam logic [SIZE_W-1:0] ROWS_MAX  = SIZE_W'(MAX_ROWS);

	typedef struct packed {
		logic [MASK_W-1:0] birth;
		logic [MASK_W-1:0] survive;
		logic              three_state;
	} rule_t;

	// Clamp a written board size into the legal range.
	function automatic logic [SIZE_W-1:0] clamp_size(input logic [CFG_DATA_W-1:0] v,
			input logic [SIZE_W-1:0] maxv);
		logic [SIZE_W-1:0] s;
		s = v[SIZE_W-1:0];
		if (s < MIN_SIZE) s = MIN_SIZE;
		if (s > maxv) s = maxv;
		return s;
	endfunction

endpackage

// ===== src/tlla_if.sv =====
// ----------------------------------------------------------------------------
// tlla_if: channel interfaces
// Command, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface tlla_item_if;
	logic                            valid;
	logic                            ready;
	logic [1:0]                      mode;
	logic [tlla_pkg::COL_W-1:0]      col;
	logic [tlla_pkg::ROW_W-1:0]      row;
	logic [tlla_pkg::CELL_W-1:0]     cell_value;
	modport source (output valid, mode, col, row, cell_value, input ready);
	modport sink (input valid, mode, col, row, cell_value, output ready);
endinterface

interface tlla_result_if;
	logic                            valid;
	logic                            ready;
	logic [tlla_pkg::CELL_W-1:0]     cell_state;
	logic [tlla_pkg::GEN_W-1:0]      generation_count;
	modport source (output valid, cell_state, generation_count, input ready);
	modport sink (input valid, cell_state, generation_count, output ready);
endinterface

interface tlla_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [tlla_pkg::CFG_IDX_W-1:0]    index;
	logic [tlla_pkg::CFG_DATA_W-1:0]   data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== src/tlla_cell.sv =====
// ----------------------------------------------------------------------------
// tlla_cell: one column cell of the update chain
// Holds the old states of the rows above and at the row being updated for
// its column, trades live bits with its neighbors and forms the next state.
// ----------------------------------------------------------------------------
module tlla_cell (
	input  logic                          clk,
	input  logic                          shift,
	input  logic [tlla_pkg::CELL_W-1:0]   down_in,
	input  tlla_pkg::rule_t               rule,
	input  logic                          active,
	input  logic [2:0]                    left_live,
	input  logic [2:0]                    right_live,
	output logic [2:0]                    own_live,
	output logic [tlla_pkg::CELL_W-1:0]   next_state
);

	logic [tlla_pkg::CELL_W-1:0] up_q;
	logic [tlla_pkg::CELL_W-1:0] mid_q;
	logic [tlla_pkg::CNT_W-1:0]  count;
	logic                        born;

	// Vertical window moves down by one row per shift.
	always_ff @(posedge clk) begin
		if (shift) begin
			up_q  <= mid_q;
			mid_q <= down_in;
		end
	end

	assign own_live = {up_q == tlla_pkg::CELL_LIVE, mid_q == tlla_pkg::CELL_LIVE,
		down_in == tlla_pkg::CELL_LIVE};

	// Eight neighbors: both side columns plus own column above and below.
	assign count = tlla_pkg::CNT_W'(left_live[0]) + tlla_pkg::CNT_W'(left_live[1])
		+ tlla_pkg::CNT_W'(left_live[2]) + tlla_pkg::CNT_W'(right_live[0])
		+ tlla_pkg::CNT_W'(right_live[1]) + tlla_pkg::CNT_W'(right_live[2])
		+ tlla_pkg::CNT_W'(own_live[0]) + tlla_pkg::CNT_W'(own_live[2]);

	assign born = rule.birth[count];

	// Rule: cells outside the board in play keep their state.
	always_comb begin
		if (!active) begin
			next_state = mid_q;
		end else if (rule.three_state) begin
			if (mid_q == tlla_pkg::CELL_LIVE) next_state = tlla_pkg::CELL_DYING;
			else if (mid_q == tlla_pkg::CELL_DYING) next_state = tlla_pkg::CELL_DEAD;
			else next_state = born ? tlla_pkg::CELL_LIVE : tlla_pkg::CELL_DEAD;
		end else if (mid_q == tlla_pkg::CELL_LIVE) begin
			next_state = rule.survive[count] ? tlla_pkg::CELL_LIVE : tlla_pkg::CELL_DEAD;
		end else begin
			next_state = born ? tlla_pkg::CELL_LIVE : tlla_pkg::CELL_DEAD;
		end
	end

endmodule

// ===== src/tlla_row.sv =====
// ----------------------------------------------------------------------------
// tlla_row: chain of column cells
// One cell per column; each cell receives the live bits of its left and
// right neighbors, wrapping at the column count in use.
// ----------------------------------------------------------------------------
module tlla_row (
	input  logic                              clk,
	input  logic                              shift,
	input  logic [tlla_pkg::ROW_BITS-1:0]     down_row,
	input  tlla_pkg::rule_t                   rule,
	input  logic [tlla_pkg::SIZE_W-1:0]       cols,
	output logic [tlla_pkg::ROW_BITS-1:0]     next_row
);

	logic [2:0]                   live [tlla_pkg::MAX_COLS];
	logic [tlla_pkg::SIZE_W-1:0]  last_col;

	assign last_col = cols - tlla_pkg::SIZE_W'(1);

	for (genvar c = 0; c < tlla_pkg::MAX_COLS; c++) begin : g_cell
		logic [2:0] left;
		logic [2:0] right;

		// Left neighbor; column zero wraps to the last column in use.
		if (c == 0) begin : g_l0
			assign left = live[last_col[tlla_pkg::COL_W-1:0]];
		end else begin : g_ln
			assign left = live[c-1];
		end

		// Right neighbor; the last column in use wraps to column zero.
		if (c == tlla_pkg::MAX_COLS - 1) begin : g_rl
			assign right = live[0];
		end else begin : g_rn
			assign right = (last_col == tlla_pkg::SIZE_W'(c)) ? live[0] : live[c+1];
		end

		tlla_cell u_cell (
			.clk        (clk),
			.shift      (shift),
			.down_in    (down_row[c*tlla_pkg::CELL_W +: tlla_pkg::CELL_W]),
			.rule       (rule),
			.active     (tlla_pkg::SIZE_W'(c) < cols),
			.left_live  (left),
			.right_live (right),
			.own_live   (live[c]),
			.next_state (next_row[c*tlla_pkg::CELL_W +: tlla_pkg::CELL_W])
		);
	end

endmodule

// ===== src/toroidal_life_like_automaton_core.sv =====
// ----------------------------------------------------------------------------
// toroidal_life_like_automaton_core: life-like automaton on a torus
// Board of two-bit cells stored one row per memory word; commands write a
// cell, read a cell or advance one generation through a chain of cells.
//
//   channel     dir  contents
//   in_item     in   mode, col, row, cell_value
//   out_result  out  cell_state, generation_count
//   cfg         in   index, data (register write, always ready)
//
// An advance feeds the cell chain from the row memory, which, with one read
// and one write port, supplies one row per cycle. Result beats go through an
// output register; a command finishes only once that register is free.
// Reset clears the row valid bits, so every row reads as dead until written;
// no clearing sweep is needed. Items are taken one at a time.
// ----------------------------------------------------------------------------
module toroidal_life_like_automaton_core (
	input  logic         clk,
	input  logic         arst_n,
	tlla_item_if.sink    in_item,
	tlla_result_if.source out_result,
	tlla_cfg_if.sink     cfg
);

	typedef enum logic [9:0] {
		S_IDLE      = 10'b0000000001,
		S_WR_RD     = 10'b0000000010,
		S_WR_WB     = 10'b0000000100,
		S_RD_RD     = 10'b0000001000,
		S_RD_SEL    = 10'b0000010000,
		S_ADV_LAST  = 10'b0000100000,
		S_ADV_FIRST = 10'b0001000000,
		S_ADV_PRIME = 10'b0010000000,
		S_ADV_ROW   = 10'b0100000000,
		S_DONE      = 10'b1000000000
	} state_t;

	state_t                            state_q;
	tlla_pkg::rule_t                   rule_q;
	logic [tlla_pkg::SIZE_W-1:0]       cols_q;
	logic [tlla_pkg::SIZE_W-1:0]       rows_q;
	logic [tlla_pkg::GEN_W-1:0]        gen_q;
	logic [tlla_pkg::COL_W-1:0]        col_q;
	logic [tlla_pkg::ROW_W-1:0]        row_q;
	logic [tlla_pkg::CELL_W-1:0]       val_q;
	logic                              inside_q;
	logic [tlla_pkg::ROW_W-1:0]        r_q;
	logic [tlla_pkg::CELL_W-1:0]       cell_q;
	logic                              out_valid_q;
	logic [tlla_pkg::CELL_W-1:0]       out_cell_q;
	logic [tlla_pkg::GEN_W-1:0]        out_gen_q;
	logic [tlla_pkg::ROW_BITS-1:0]     first_q;
	logic [tlla_pkg::MAX_ROWS-1:0]     row_valid_q;

	logic [tlla_pkg::ROW_BITS-1:0]     mem [tlla_pkg::MAX_ROWS];
	logic [tlla_pkg::ROW_BITS-1:0]     rdata_q;
	logic                              rvalid_q;
	logic [tlla_pkg::ROW_BITS-1:0]     row_data;

	logic                              rd_en;
	logic [tlla_pkg::ROW_W-1:0]        rd_addr;
	logic                              wr_en;
	logic [tlla_pkg::ROW_W-1:0]        wr_addr;
	logic [tlla_pkg::ROW_BITS-1:0]     wr_data;
	logic [tlla_pkg::ROW_BITS-1:0]     merged;
	logic [tlla_pkg::ROW_BITS-1:0]     down_row;
	logic [tlla_pkg::ROW_BITS-1:0]     next_row;
	logic                              shift;
	logic                              last_row;
	logic [tlla_pkg::SIZE_W-1:0]       rows_m1;
	logic [tlla_pkg::SIZE_W-1:0]       r_plus2;
	logic                              in_beat;

	assign in_beat   = in_item.valid && in_item.ready;
	assign in_item.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;

	assign out_result.valid            = out_valid_q;
	assign out_result.cell_state       = out_cell_q;
	assign out_result.generation_count = out_gen_q;

	assign rows_m1  = rows_q - tlla_pkg::SIZE_W'(1);
	assign r_plus2  = {1'b0, r_q} + tlla_pkg::SIZE_W'(2);
	assign last_row = ({1'b0, r_q} == rows_m1);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rule_q.birth       <= tlla_pkg::MASK_W'(8);
			rule_q.survive     <= tlla_pkg::MASK_W'(12);
			rule_q.three_state <= 1'b0;
			cols_q             <= tlla_pkg::COLS_MAX;
			rows_q             <= tlla_pkg::ROWS_MAX;
		end else if (cfg.valid) begin
			case (cfg.index)
				tlla_pkg::REG_BIRTH:   rule_q.birth       <= cfg.data;
				tlla_pkg::REG_SURVIVE: rule_q.survive     <= cfg.data;
				tlla_pkg::REG_THREE:   rule_q.three_state <= cfg.data[0];
				tlla_pkg::REG_COLS:    cols_q <= tlla_pkg::clamp_size(cfg.data,
					tlla_pkg::COLS_MAX);
				tlla_pkg::REG_ROWS:    rows_q <= tlla_pkg::clamp_size(cfg.data,
					tlla_pkg::ROWS_MAX);
				default: ;
			endcase
		end
	end

	// Row memory port selection.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = row_q;
		case (state_q)
			S_WR_RD, S_RD_RD: rd_en = 1'b1;
			S_ADV_LAST: begin
				rd_en   = 1'b1;
				rd_addr = rows_m1[tlla_pkg::ROW_W-1:0];
			end
			S_ADV_FIRST: begin
				rd_en   = 1'b1;
				rd_addr = '0;
			end
			S_ADV_PRIME: begin
				rd_en   = 1'b1;
				rd_addr = tlla_pkg::ROW_W'(1);
			end
			S_ADV_ROW: begin
				rd_en   = (r_plus2 < rows_q);
				rd_addr = r_plus2[tlla_pkg::ROW_W-1:0];
			end
			default: ;
		endcase
	end

	// Rows never written read as all dead.
	assign row_data = rvalid_q ? rdata_q : '0;

	always_comb begin
		merged = row_data;
		merged[{col_q, 1'b0} +: tlla_pkg::CELL_W] =
			(val_q == tlla_pkg::CELL_BAD) ? tlla_pkg::CELL_DEAD : val_q;
	end

	assign shift    = (state_q == S_ADV_FIRST) || (state_q == S_ADV_PRIME)
		|| (state_q == S_ADV_ROW);
	assign down_row = ((state_q == S_ADV_ROW) && last_row) ? first_q : row_data;

	assign wr_en   = ((state_q == S_WR_WB) && inside_q) || (state_q == S_ADV_ROW);
	assign wr_addr = (state_q == S_ADV_ROW) ? r_q : row_q;
	assign wr_data = (state_q == S_ADV_ROW) ? next_row : merged;

	// Board memory, one row per word.
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) begin
			rdata_q  <= mem[rd_addr];
			rvalid_q <= row_valid_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
		end else if (wr_en) begin
			row_valid_q[wr_addr] <= 1'b1;
		end
	end

	tlla_row u_row (
		.clk      (clk),
		.shift    (shift),
		.down_row (down_row),
		.rule     (rule_q),
		.cols     (cols_q),
		.next_row (next_row)
	);

	// Command sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			gen_q       <= '0;
			out_valid_q <= 1'b0;
			r_q         <= '0;
		end else begin
			// The result register loads when a command finishes, else empties on a beat.
			if ((state_q == S_DONE) && (!out_valid_q || out_result.ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_beat) begin
						case (in_item.mode)
							tlla_pkg::MODE_WRITE:   state_q <= S_WR_RD;
							tlla_pkg::MODE_READ:    state_q <= S_RD_RD;
							tlla_pkg::MODE_ADVANCE: state_q <= S_ADV_LAST;
							default:                state_q <= S_DONE;
						endcase
					end
				end
				S_WR_RD:     state_q <= S_WR_WB;
				S_WR_WB:     state_q <= S_DONE;
				S_RD_RD:     state_q <= S_RD_SEL;
				S_RD_SEL:    state_q <= S_DONE;
				S_ADV_LAST:  state_q <= S_ADV_FIRST;
				S_ADV_FIRST: state_q <= S_ADV_PRIME;
				S_ADV_PRIME: begin
					r_q     <= '0;
					state_q <= S_ADV_ROW;
				end
				S_ADV_ROW: begin
					if (last_row) begin
						gen_q   <= gen_q + tlla_pkg::GEN_W'(1);
						state_q <= S_DONE;
					end else begin
						r_q <= r_q + tlla_pkg::ROW_W'(1);
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_result.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Command fields, result data and the saved old row zero.
	always_ff @(posedge clk) begin
		if (in_beat) begin
			col_q    <= in_item.col;
			row_q    <= in_item.row;
			val_q    <= in_item.cell_value;
			inside_q <= ({1'b0, in_item.col} < cols_q) && ({1'b0, in_item.row} < rows_q);
			cell_q   <= tlla_pkg::CELL_DEAD;
		end
		if (state_q == S_RD_SEL) begin
			cell_q <= inside_q ? row_data[{col_q, 1'b0} +: tlla_pkg::CELL_W]
				: tlla_pkg::CELL_DEAD;
		end
		if (state_q == S_ADV_PRIME) first_q <= row_data;
		if ((state_q == S_DONE) && (!out_valid_q || out_result.ready)) begin
			out_cell_q <= cell_q;
			out_gen_q  <= gen_q;
		end
	end

endmodule

// ===== tb/sv/tb_life_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_life_checker: board predictor and result scoreboard
// Watches the command, result and register channels, keeps its own copy
// of the board and rules, and compares every result beat with the oldest
// predicted one.
// ----------------------------------------------------------------------------
module tb_life_checker
	import tlla_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	tlla_item_if   item_ch,
	tlla_result_if res_ch,
	tlla_cfg_if    cfg_ch,
	output int     pending,
	output int     fails
);

	typedef struct {
		logic [CELL_W-1:0] cell_state;
		logic [GEN_W-1:0]  gen;
	} life_result_t;

	logic [CELL_W-1:0] board [MAX_ROWS][MAX_COLS];
	logic [CELL_W-1:0] next_board [MAX_ROWS][MAX_COLS];
	logic [GEN_W-1:0]  gen_now;
	logic [MASK_W-1:0] birth_rule;
	logic [MASK_W-1:0] survive_rule;
	logic              brain_mode;
	int                board_cols;
	int                board_rows;
	life_result_t      awaited_results[$];

	// Board size as stored: low seven bits, held within 3 and the maximum.
	function automatic int fit_size(logic [CFG_DATA_W-1:0] v, int maxv);
		int s;
		s = v[SIZE_W-1:0];
		if (s < 3) s = 3;
		if (s > maxv) s = maxv;
		return s;
	endfunction

	function automatic int live_at(int r, int c);
		return (board[r][c] == CELL_LIVE) ? 1 : 0;
	endfunction

	// One generation over the cells in play, all updated from the old board.
	task automatic step_generation();
		int up, dn, lf, rt, n;
		logic [CELL_W-1:0] cur;
		logic born;
		next_board = board;
		for (int r = 0; r < board_rows; r++) begin
			up = (r == 0) ? board_rows - 1 : r - 1;
			dn = (r + 1 == board_rows) ? 0 : r + 1;
			for (int c = 0; c < board_cols; c++) begin
				lf = (c == 0) ? board_cols - 1 : c - 1;
				rt = (c + 1 == board_cols) ? 0 : c + 1;
				n = live_at(up, lf) + live_at(up, c) + live_at(up, rt)
					+ live_at(r, lf) + live_at(r, rt)
					+ live_at(dn, lf) + live_at(dn, c) + live_at(dn, rt);
				cur = board[r][c];
				born = birth_rule[n];
				if (brain_mode) begin
					if (cur == CELL_LIVE) next_board[r][c] = CELL_DYING;
					else if (cur == CELL_DYING) next_board[r][c] = CELL_DEAD;
					else next_board[r][c] = born ? CELL_LIVE : CELL_DEAD;
				end else if (cur == CELL_LIVE) begin
					next_board[r][c] = survive_rule[n] ? CELL_LIVE : CELL_DEAD;
				end else begin
					next_board[r][c] = born ? CELL_LIVE : CELL_DEAD;
				end
			end
		end
		board = next_board;
		gen_now = gen_now + 1'b1;
	endtask

	// Predict the result of one accepted command beat.
	task automatic predict_command(logic [1:0] mode, int c, int r, logic [CELL_W-1:0] v);
		life_result_t e;
		logic in_play;
		in_play = (c < board_cols) && (r < board_rows);
		e.cell_state = CELL_DEAD;
		case (mode)
			MODE_WRITE: begin
				if (in_play) board[r][c] = (v == CELL_BAD) ? CELL_DEAD : v;
			end
			MODE_READ: begin
				if (in_play) e.cell_state = board[r][c];
			end
			MODE_ADVANCE: begin
				step_generation();
			end
			default: ;
		endcase
		e.gen = gen_now;
		awaited_results.push_back(e);
	endtask

	always @(posedge clk or negedge arst_n) begin
		life_result_t e;
		if (!arst_n) begin
			for (int r = 0; r < MAX_ROWS; r++)
				for (int c = 0; c < MAX_COLS; c++)
					board[r][c] = CELL_DEAD;
			gen_now = '0;
			birth_rule = 9'd8;
			survive_rule = 9'd12;
			brain_mode = 1'b0;
			board_cols = MAX_COLS;
			board_rows = MAX_ROWS;
			awaited_results.delete();
			fails = 0;
		end else begin
			// Register writes land before any command beat of the same edge.
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_ch.index)
					REG_BIRTH:   birth_rule = cfg_ch.data;
					REG_SURVIVE: survive_rule = cfg_ch.data;
					REG_THREE:   brain_mode = cfg_ch.data[0];
					REG_COLS:    board_cols = fit_size(cfg_ch.data, MAX_COLS);
					REG_ROWS:    board_rows = fit_size(cfg_ch.data, MAX_ROWS);
					default: ;
				endcase
			end
			if (item_ch.valid && item_ch.ready)
				predict_command(item_ch.mode, item_ch.col, item_ch.row, item_ch.cell_value);
			// Compare each result beat with the oldest prediction.
			if (res_ch.valid && res_ch.ready) begin
				if (awaited_results.size() == 0) begin
					$display("%0t: unexpected result beat: state %0d gen %0d", $time,
						res_ch.cell_state, res_ch.generation_count);
					fails++;
				end else begin
					e = awaited_results.pop_front();
					if (res_ch.cell_state !== e.cell_state) begin
						$display("%0t: cell_state expected %0d actual %0d", $time,
							e.cell_state, res_ch.cell_state);
						fails++;
					end
					if (res_ch.generation_count !== e.gen) begin
						$display("%0t: generation_count expected %0d actual %0d", $time,
							e.gen, res_ch.generation_count);
						fails++;
					end
				end
			end
		end
		pending = awaited_results.size();
	end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for the toroidal life-like automaton
// Drives cell writes, reads and generation steps under several rule sets
// and board sizes, with random idling on both sides; the checker predicts
// and compares every result beat.
// ----------------------------------------------------------------------------
module tb;
	import tlla_pkg::*;

	localparam logic [1:0]           MODE_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam int                   STALL_LIMIT = 5000;
	localparam int                   SETTLE_CYCLES = 80;

	logic clk;
	logic arst_n;
	int   pending;
	int   fails;
	int   send_idle;
	int   recv_idle;
	int   quiet_cycles;
	int   play_cols;
	int   play_rows;

	tlla_item_if   item_ch();
	tlla_result_if res_ch();
	tlla_cfg_if    cfg_ch();

	toroidal_life_like_automaton_core uut (
		.clk(clk), .arst_n(arst_n), .in_item(item_ch), .out_result(res_ch), .cfg(cfg_ch)
	);

	tb_life_checker chk (
		.clk(clk), .arst_n(arst_n), .item_ch(item_ch), .res_ch(res_ch), .cfg_ch(cfg_ch),
		.pending(pending), .fails(fails)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Result side stalls at random.
	always @(posedge clk) begin
		res_ch.ready <= ($urandom_range(99) >= recv_idle);
	end

	// Watchdog: too long without any beat on any channel ends the run.
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic int fit_size(logic [CFG_DATA_W-1:0] v, int maxv);
		int s;
		s = v[SIZE_W-1:0];
		if (s < 3) s = 3;
		if (s > maxv) s = maxv;
		return s;
	endfunction

	// Send one command beat; valid stays high into the next beat unless idling.
	task automatic send_command(logic [1:0] mode, logic [5:0] c, logic [5:0] r,
			logic [1:0] v);
		if ($urandom_range(99) < send_idle) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.mode <= mode;
		item_ch.col <= c;
		item_ch.row <= r;
		item_ch.cell_value <= v;
		do @(posedge clk); while (!item_ch.ready);
	endtask

	// Let every predicted result arrive, then let the block settle.
	task automatic drain_results();
		item_ch.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= d;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		if (idx == REG_COLS) play_cols = fit_size(d, MAX_COLS);
		if (idx == REG_ROWS) play_rows = fit_size(d, MAX_ROWS);
		@(posedge clk);
	endtask

	// Mostly pattern writes and reads inside the board, some generation steps.
	task automatic random_commands(int count);
		int pick;
		logic [1:0] mode;
		logic [5:0] c, r;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			if (pick < 45) mode = MODE_WRITE;
			else if (pick < 80) mode = MODE_READ;
			else if (pick < 95) mode = MODE_ADVANCE;
			else mode = MODE_UNUSED;
			if ($urandom_range(99) < 80) begin
				c = 6'($urandom_range(play_cols - 1));
				r = 6'($urandom_range(play_rows - 1));
			end else begin
				c = 6'($urandom_range(63));
				r = 6'($urandom_range(63));
			end
			send_command(mode, c, r, 2'($urandom_range(3)));
			if (i == count / 2 && send_idle > 0) drain_results();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.mode = MODE_WRITE;
		item_ch.col = '0;
		item_ch.row = '0;
		item_ch.cell_value = CELL_DEAD;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_BIRTH;
		cfg_ch.data = '0;
		res_ch.ready = 1'b0;
		quiet_cycles = 0;
		send_idle = 34;
		recv_idle = 62;
		play_cols = MAX_COLS;
		play_rows = MAX_ROWS;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: blinker across both wrap edges, corners, odd cell values.
		write_register(REG_BIRTH, 9'd8);
		write_register(REG_SURVIVE, 9'd12);
		send_command(MODE_WRITE, 6'd63, 6'd63, CELL_LIVE);
		send_command(MODE_WRITE, 6'd0, 6'd63, CELL_LIVE);
		send_command(MODE_WRITE, 6'd1, 6'd63, CELL_LIVE);
		send_command(MODE_WRITE, 6'd0, 6'd0, CELL_LIVE);
		send_command(MODE_WRITE, 6'd5, 6'd5, CELL_LIVE);
		send_command(MODE_WRITE, 6'd5, 6'd5, CELL_BAD);
		send_command(MODE_READ, 6'd5, 6'd5, CELL_BAD);
		send_command(MODE_WRITE, 6'd10, 6'd10, CELL_DYING);
		send_command(MODE_READ, 6'd10, 6'd10, CELL_DEAD);
		send_command(MODE_READ, 6'd63, 6'd63, CELL_DEAD);
		send_command(MODE_ADVANCE, 6'd63, 6'd63, CELL_BAD);
		send_command(MODE_READ, 6'd0, 6'd62, CELL_DEAD);
		send_command(MODE_READ, 6'd0, 6'd0, CELL_DEAD);
		send_command(MODE_READ, 6'd10, 6'd10, CELL_DEAD);
		send_command(MODE_UNUSED, 6'd63, 6'd63, CELL_LIVE);
		send_command(MODE_ADVANCE, 6'd0, 6'd0, CELL_DEAD);
		send_command(MODE_READ, 6'd63, 6'd63, CELL_DEAD);
		send_command(MODE_READ, 6'd1, 6'd63, CELL_DEAD);
		random_commands(37);
		drain_results();

		// Brian's Brain on a clamped tiny board; spare indexes are ignored.
		send_idle = 62;
		recv_idle = 34;
		write_register(REG_THREE, 9'd1);
		write_register(REG_BIRTH, 9'd4);
		write_register(REG_COLS, 9'd2);
		write_register(REG_ROWS, 9'd5);
		write_register(REG_SPARE_LO, 9'h1FF);
		write_register(REG_SPARE_HI, 9'h0AA);
		random_commands(37);
		drain_results();

		// Two-state, no births and full survival, wide and short board.
		send_idle = 0;
		recv_idle = 0;
		write_register(REG_THREE, 9'd0);
		write_register(REG_BIRTH, 9'h000);
		write_register(REG_SURVIVE, 9'h1FF);
		write_register(REG_COLS, 9'h1FF);
		write_register(REG_ROWS, 9'd3);
		random_commands(24);
		drain_results();
		write_register(REG_BIRTH, 9'h1FF);
		write_register(REG_SURVIVE, 9'h000);
		write_register(REG_ROWS, 9'd100);
		random_commands(24);

		drain_results();
		if (fails == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
